@@ sv/jsfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types, codes and character constants of the JSON string field
// extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

	localparam int KEY_MAX_DEF   = 16;
	localparam int VALUE_MAX_DEF = 4096;

	localparam int KLEN_W  = 5;
	localparam int KREG_W  = 64;
	localparam int VLIM_W  = 13;
	localparam int CIDX_W  = 2;

	localparam logic [VLIM_W-1:0] VLIM_RESET = 13'd256;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_KEY_LEN = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_KEY_LO  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_KEY_HI  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_VLIMIT  = 2'd3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LBRACE = 8'h7B;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_VALUE  = 3'b010,
		PH_FIN    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       done_res;
		logic       found;
	} res_t;

	// up to two result words per document byte
	typedef struct packed {
		logic vld0;
		logic vld1;
		res_t r0;
		res_t r1;
	} push_t;

	typedef struct packed {
		logic step;
		logic clear;
	} mctl_t;

	function automatic res_t mk_res(input logic [7:0] b, input logic v, input logic d,
		input logic f);
		res_t r;
		r.value_byte = b;
		r.byte_valid = v;
		r.done_res   = d;
		r.found      = f;
		return r;
	endfunction

endpackage

@@ sv/jsfe_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_matcher
// Byte window and context flags; flags an accepted key pattern on the
// current byte.
// ----------------------------------------------------------------------------
module jsfe_matcher #(
	parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jsfe_pkg::mctl_t                 mctl,
	input  logic [7:0]                      doc_byte,
	input  logic [jsfe_pkg::KLEN_W-1:0]     key_len,
	input  logic [jsfe_pkg::KREG_W-1:0]     key_lo,
	input  logic [jsfe_pkg::KREG_W-1:0]     key_hi,
	output logic                            accept
);

	localparam int WIN  = KEY_MAX + 4;
	localparam int BS_W = $clog2(WIN + 1);
	localparam int WI_W = $clog2(WIN);
	localparam int KL_W = $clog2(KEY_MAX + 1);
	localparam int KI_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	logic [7:0]      win_q [WIN];
	logic [7:0]      win_n [WIN];
	logic [WIN-1:0]  ctx_q;
	logic [WIN-1:0]  ctx_n;
	logic            ctx_now_q;
	logic [BS_W-1:0] seen_q;
	logic [BS_W-1:0] seen_n;
	logic [BS_W-1:0] skip_q;

	logic [7:0]      key_arr [KEY_MAX];
	logic [KL_W-1:0] klen;
	logic [BS_W-1:0] plen;
	logic [BS_W-1:0] pm1;
	logic [BS_W-1:0] kidx;
	logic [7:0]      exp_b;
	logic            matched;
	logic            ctx_sel;
	logic            reject;

	always_comb begin
		for (int k = 0; k < KEY_MAX; k++) begin
			if (k < 8) begin
				key_arr[k] = key_lo[k*8 +: 8];
			end else begin
				key_arr[k] = key_hi[(k-8)*8 +: 8];
			end
		end
	end

	assign klen = (key_len > jsfe_pkg::KLEN_W'(KEY_MAX)) ? KL_W'(KEY_MAX) : KL_W'(key_len);
	assign plen = BS_W'(klen) + BS_W'(4);
	assign pm1  = plen - BS_W'(1);

	always_comb begin
		win_n[0] = doc_byte;
		for (int j = 1; j < WIN; j++) begin
			win_n[j] = win_q[j-1];
		end
	end

	assign ctx_n  = {ctx_q[WIN-2:0], ctx_now_q};
	assign seen_n = (seen_q < BS_W'(WIN)) ? seen_q + BS_W'(1) : seen_q;

	// window slot j holds pattern byte plen-1-j
	always_comb begin
		matched = (seen_n >= plen);
		kidx    = '0;
		exp_b   = jsfe_pkg::CH_QUOTE;
		for (int j = 0; j < WIN; j++) begin
			kidx = BS_W'(klen) + BS_W'(2) - BS_W'(j);
			if (j == 1) begin
				exp_b = jsfe_pkg::CH_COLON;
			end else if (j == 0 || j == 2 || BS_W'(j) == pm1) begin
				exp_b = jsfe_pkg::CH_QUOTE;
			end else begin
				exp_b = key_arr[kidx[KI_W-1:0]];
			end
			if (BS_W'(j) < plen && win_n[j] != exp_b) begin
				matched = 1'b0;
			end
		end
	end

	assign ctx_sel = ctx_n[pm1[WI_W-1:0]];
	assign accept  = (skip_q == '0) && matched && ctx_sel;
	assign reject  = (skip_q == '0) && matched && !ctx_sel;

	always_ff @(posedge clk) begin
		if (mctl.step) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q     <= '1;
			ctx_now_q <= 1'b1;
			seen_q    <= '0;
			skip_q    <= '0;
		end else if (mctl.clear) begin
			ctx_q     <= '1;
			ctx_now_q <= 1'b1;
			seen_q    <= '0;
			skip_q    <= '0;
		end else if (mctl.step) begin
			ctx_q  <= ctx_n;
			seen_q <= seen_n;
			if (seen_q == '0) begin
				ctx_now_q <= 1'b1;
			end else if (doc_byte != jsfe_pkg::CH_SPACE && doc_byte != jsfe_pkg::CH_TAB) begin
				ctx_now_q <= (doc_byte == jsfe_pkg::CH_LBRACE) ||
					(doc_byte == jsfe_pkg::CH_COMMA);
			end
			if (skip_q != '0) begin
				skip_q <= skip_q - BS_W'(1);
			end else if (reject) begin
				skip_q <= pm1;
			end
		end
	end

endmodule

@@ sv/jsfe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_ctrl
// Document phase, value unescaping and byte budget; builds the result words
// of each document byte.
// ----------------------------------------------------------------------------
module jsfe_ctrl #(
	parameter int VALUE_MAX = jsfe_pkg::VALUE_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  doc_byte,
	input  logic                        doc_end,
	input  logic                        accept,
	input  logic [jsfe_pkg::VLIM_W-1:0] vlim,
	output jsfe_pkg::mctl_t             mctl,
	output jsfe_pkg::push_t             push
);

	localparam int LIM_W = $clog2(VALUE_MAX + 1);
	localparam int CMP_W = (LIM_W > jsfe_pkg::VLIM_W) ? LIM_W : jsfe_pkg::VLIM_W;
	localparam int CNT_W = $clog2(VALUE_MAX);

	jsfe_pkg::phase_t ph_q;
	jsfe_pkg::phase_t ph_n;
	logic             esc_q;
	logic             esc_n;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_n;

	logic [CMP_W-1:0] vl;
	logic [CMP_W-1:0] lim;
	logic [CMP_W-1:0] cnt_new;
	logic [7:0]       ch;
	logic             em;
	logic             fin;

	assign vl  = CMP_W'(vlim);
	assign lim = (vl == '0) ? CMP_W'(1) :
		(vl > CMP_W'(VALUE_MAX)) ? CMP_W'(VALUE_MAX) : vl;

	assign mctl.step  = step && (ph_q == jsfe_pkg::PH_SEARCH) && (doc_byte != jsfe_pkg::CH_NUL);
	assign mctl.clear = step && doc_end;

	always_comb begin
		ph_n      = ph_q;
		esc_n     = esc_q;
		cnt_n     = cnt_q;
		cnt_new   = CMP_W'(cnt_q);
		ch        = doc_byte;
		em        = 1'b0;
		fin       = 1'b0;
		push.vld0 = 1'b0;
		push.vld1 = 1'b0;
		push.r0   = jsfe_pkg::mk_res(jsfe_pkg::CH_NUL, 1'b0, 1'b1, 1'b1);
		push.r1   = jsfe_pkg::mk_res(jsfe_pkg::CH_NUL, 1'b0, 1'b1, 1'b1);
		case (ph_q)
			jsfe_pkg::PH_SEARCH: begin
				if (doc_byte == jsfe_pkg::CH_NUL) begin
					push.vld0 = 1'b1;
					push.r0.found = 1'b0;
					ph_n = jsfe_pkg::PH_FIN;
				end else if (accept) begin
					if (lim == CMP_W'(1) || doc_end) begin
						push.vld0 = 1'b1;
						ph_n = jsfe_pkg::PH_FIN;
					end else begin
						ph_n  = jsfe_pkg::PH_VALUE;
						cnt_n = '0;
					end
				end else if (doc_end) begin
					push.vld0 = 1'b1;
					push.r0.found = 1'b0;
				end
			end
			jsfe_pkg::PH_VALUE: begin
				if (doc_byte == jsfe_pkg::CH_NUL) begin
					// a dangling backslash goes out as itself
					if (esc_q) begin
						push.vld0 = 1'b1;
						push.vld1 = 1'b1;
						push.r0 = jsfe_pkg::mk_res(jsfe_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0);
					end else begin
						push.vld0 = 1'b1;
					end
					ph_n = jsfe_pkg::PH_FIN;
				end else if (!esc_q && doc_byte == jsfe_pkg::CH_QUOTE) begin
					push.vld0 = 1'b1;
					ph_n = jsfe_pkg::PH_FIN;
				end else begin
					if (esc_q) begin
						esc_n = 1'b0;
						em    = 1'b1;
						case (doc_byte)
							jsfe_pkg::CH_N: ch = jsfe_pkg::CH_LF;
							jsfe_pkg::CH_R: ch = jsfe_pkg::CH_CR;
							jsfe_pkg::CH_T: ch = jsfe_pkg::CH_TAB;
							default:        ch = doc_byte;
						endcase
					end else if (doc_byte == jsfe_pkg::CH_BSLASH) begin
						if (doc_end) begin
							em = 1'b1;
						end else begin
							esc_n = 1'b1;
						end
					end else begin
						em = 1'b1;
					end
					cnt_new = em ? CMP_W'(cnt_q) + CMP_W'(1) : CMP_W'(cnt_q);
					cnt_n   = cnt_new[CNT_W-1:0];
					fin     = (cnt_new >= lim - CMP_W'(1)) || doc_end;
					if (fin) begin
						ph_n = jsfe_pkg::PH_FIN;
					end
					if (em) begin
						push.vld0 = 1'b1;
						push.vld1 = fin;
						push.r0 = jsfe_pkg::mk_res(ch, 1'b1, 1'b0, 1'b0);
					end else begin
						push.vld0 = fin;
					end
				end
			end
			jsfe_pkg::PH_FIN: begin
				ph_n = jsfe_pkg::PH_FIN;
			end
			default: begin
				ph_n = jsfe_pkg::PH_SEARCH;
			end
		endcase
		if (doc_end) begin
			ph_n  = jsfe_pkg::PH_SEARCH;
			esc_n = 1'b0;
			cnt_n = '0;
		end
		if (!step) begin
			push.vld0 = 1'b0;
			push.vld1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= jsfe_pkg::PH_SEARCH;
			esc_q <= 1'b0;
			cnt_q <= '0;
		end else if (step) begin
			ph_q  <= ph_n;
			esc_q <= esc_n;
			cnt_q <= cnt_n;
		end
	end

endmodule

@@ sv/jsfe_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_outq
// Two-word result queue: output register plus one spare for the second word
// of a byte.
// ----------------------------------------------------------------------------
module jsfe_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  jsfe_pkg::push_t push,
	input  logic            pop_ready,
	output logic            room,
	output logic            head_valid,
	output jsfe_pkg::res_t  head
);

	logic           o_v_q;
	logic           x_v_q;
	jsfe_pkg::res_t o_q;
	jsfe_pkg::res_t x_q;

	// room for two words when the spare is empty and the head leaves or is empty
	assign room       = !x_v_q && (!o_v_q || pop_ready);
	assign head_valid = o_v_q;
	assign head       = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			x_v_q <= 1'b0;
		end else if (room) begin
			o_v_q <= push.vld0;
			x_v_q <= push.vld1;
		end else if (pop_ready && o_v_q) begin
			o_v_q <= x_v_q;
			x_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (room) begin
			o_q <= push.r0;
			x_q <= push.r1;
		end else if (pop_ready && o_v_q) begin
			o_q <= x_q;
		end
	end

endmodule

@@ sv/json_string_field_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Streams document bytes, finds the configured key field and emits its
// string value unescaped, then a done word with the found flag.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_axis   in   tvalid/tready        tdata doc_byte, tlast doc_end
//  m_axis   out  tvalid/tready        tdata value_byte, tlast done_res,
//                                     tuser {found, byte_valid}
//  cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while the output does not stall; a byte is registered in the
// input stage and its word then in the output register.
// A byte that yields two words (value byte plus done) holds the input
// while the spare word drains through the output register.
// Reset clears all control state at once; no clearing pass.
// Beyond that, the input stalls only when the output side back-pressures.
// ----------------------------------------------------------------------------
module json_string_field_extractor #(
	parameter int KEY_MAX   = jsfe_pkg::KEY_MAX_DEF,
	parameter int VALUE_MAX = jsfe_pkg::VALUE_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // [7:0] doc_byte
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,   // [7:0] value_byte
	output logic                        m_axis_tlast,
	output logic [1:0]                  m_axis_tuser,   // [0] byte_valid, [1] found
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [jsfe_pkg::CIDX_W-1:0] cfg_index,
	input  logic [jsfe_pkg::KREG_W-1:0] cfg_data
);

	logic [jsfe_pkg::KLEN_W-1:0] key_len_q;
	logic [jsfe_pkg::KREG_W-1:0] key_lo_q;
	logic [jsfe_pkg::KREG_W-1:0] key_hi_q;
	logic [jsfe_pkg::VLIM_W-1:0] vlim_q;

	logic       in_v_s1;
	logic [7:0] in_byte_s1;
	logic       in_end_s1;

	logic            room;
	logic            proc;
	logic            accept;
	jsfe_pkg::mctl_t mctl;
	jsfe_pkg::push_t push;
	jsfe_pkg::res_t  head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			vlim_q    <= jsfe_pkg::VLIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jsfe_pkg::CFG_KEY_LEN: key_len_q <= cfg_data[jsfe_pkg::KLEN_W-1:0];
				jsfe_pkg::CFG_KEY_LO:  key_lo_q  <= cfg_data;
				jsfe_pkg::CFG_KEY_HI:  key_hi_q  <= cfg_data;
				jsfe_pkg::CFG_VLIMIT:  vlim_q    <= cfg_data[jsfe_pkg::VLIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign proc          = in_v_s1 && room;
	assign s_axis_tready = !in_v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_v_s1 <= 1'b1;
		end else if (proc) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
			in_end_s1  <= s_axis_tlast;
		end
	end

	jsfe_matcher #(
		.KEY_MAX (KEY_MAX)
	) u_matcher (
		.clk      (clk),
		.arst_n   (arst_n),
		.mctl     (mctl),
		.doc_byte (in_byte_s1),
		.key_len  (key_len_q),
		.key_lo   (key_lo_q),
		.key_hi   (key_hi_q),
		.accept   (accept)
	);

	jsfe_ctrl #(
		.VALUE_MAX (VALUE_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (proc),
		.doc_byte (in_byte_s1),
		.doc_end  (in_end_s1),
		.accept   (accept),
		.vlim     (vlim_q),
		.mctl     (mctl),
		.push     (push)
	);

	jsfe_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop_ready  (m_axis_tready),
		.room       (room),
		.head_valid (m_axis_tvalid),
		.head       (head)
	);

	assign m_axis_tdata = head.value_byte;
	assign m_axis_tlast = head.done_res;
	assign m_axis_tuser = {head.found, head.byte_valid};

endmodule
